>>> src/iyr_pkg.sv
// Shared types and constants for the yaw-rate integrator.
`timescale 1ns / 1ps

package iyr_pkg;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_ZERO   = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 1'b1;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [23:0] GYRO_BIAS_RST = 24'sd0;
  localparam logic [15:0]        MAX_STEP_RST  = 16'd100;

  localparam int SMOOTH_DIVISOR_DEF = 8;
  // reciprocal for the averaging divide stays below 2^18 for divisors 2..256
  localparam int SMOOTH_RECIP_W = 18;

  localparam int NUM_AXES   = 6;
  localparam int AXIS_IDX_W = 3;
  localparam logic [AXIS_IDX_W-1:0] LAST_STEP = AXIS_IDX_W'(NUM_AXES - 1);

  // run steps at which the scalar chain writes back
  localparam logic [AXIS_IDX_W-1:0] STEP_RATE_WR = 3'd1;
  localparam logic [AXIS_IDX_W-1:0] STEP_YAW_WR  = 3'd4;

  // rate = floor(floor(|d|*10 / 128) / 131), 65.5 * 256 = 128 * 131
  localparam int RATE_SHIFT = 29;
  localparam logic [22:0] RATE_RECIP = 23'(((64'd1 << RATE_SHIFT) + 131 - 1) / 131);

  // yaw step = floor(floor(|d|*dt / 512) / 3275), 1676800 = 512 * 3275
  localparam int STEP_SHIFT = 43;
  localparam logic [31:0] STEP_RECIP = 32'(((64'd1 << STEP_SHIFT) + 3275 - 1) / 3275);

  // step modulo one full turn
  localparam int YAW_HALF = 1800;
  localparam int YAW_FULL = 3600;
  localparam int WRAP_SHIFT = 32;
  localparam logic [20:0] WRAP_RECIP =
    21'(((64'd1 << WRAP_SHIFT) + YAW_FULL - 1) / YAW_FULL);

  typedef struct packed {
    logic                  capture;   // input beat taken this cycle
    logic                  run;       // compute step active
    logic [AXIS_IDX_W-1:0] step;      // compute step index, also axis index
    logic                  load_out;  // copy results into output register
  } iyr_cmd_t;

endpackage

>>> src/iyr_ctrl.sv
// Sequencer for the yaw-rate integrator: handshakes and compute steps.
`timescale 1ns / 1ps

module iyr_ctrl
  import iyr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output iyr_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [AXIS_IDX_W-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;
  logic                  out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == LAST_STEP) begin
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture  = accept;
    cmd_o.run      = (state_q == ST_RUN);
    cmd_o.step     = cnt_q;
    cmd_o.load_out = (state_q == ST_LOAD) & out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/iyr_datapath.sv
// Datapath: config registers, axis averages, rate and heading arithmetic.
`timescale 1ns / 1ps

module iyr_datapath
  import iyr_pkg::*;
#(
  parameter int SMOOTH_DIVISOR = SMOOTH_DIVISOR_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  iyr_cmd_t              cmd_i,
  input  logic                  req_type_i,
  input  logic signed [15:0]    accel_x_i,
  input  logic signed [15:0]    accel_y_i,
  input  logic signed [15:0]    accel_z_i,
  input  logic signed [15:0]    gyro_x_i,
  input  logic signed [15:0]    gyro_y_i,
  input  logic signed [15:0]    gyro_z_i,
  input  logic [31:0]           time_ms_i,
  output logic signed [11:0]    yaw_tenths_o,
  output logic signed [14:0]    rate_tenths_o,
  output logic signed [15:0]    smooth_accel_x_o,
  output logic signed [15:0]    smooth_accel_y_o,
  output logic signed [15:0]    smooth_accel_z_o,
  output logic signed [15:0]    smooth_gyro_x_o,
  output logic signed [15:0]    smooth_gyro_y_o,
  output logic signed [15:0]    smooth_gyro_z_o
);

  // exact floor(n / SMOOTH_DIVISOR) for n < 2^16 by reciprocal multiply
  localparam int SMOOTH_SHIFT = 16 + $clog2(SMOOTH_DIVISOR);
  localparam logic [SMOOTH_RECIP_W-1:0] SMOOTH_RECIP =
    SMOOTH_RECIP_W'(((64'd1 << SMOOTH_SHIFT) + SMOOTH_DIVISOR - 1) / SMOOTH_DIVISOR);
  localparam int AX_PROD_W = 16 + SMOOTH_RECIP_W;

  localparam logic signed [13:0] YAW_HALF_S = 14'(YAW_HALF);
  localparam logic signed [13:0] YAW_FULL_S = 14'(YAW_FULL);
  localparam logic [11:0]        YAW_FULL_U = 12'(YAW_FULL);

  // config and architectural state
  logic signed [23:0] bias_q;
  logic [15:0]        max_step_q;
  logic signed [15:0] avg_q [NUM_AXES];
  logic signed [11:0] heading_q;
  logic signed [14:0] rate_q;
  logic [31:0]        last_time_q;
  logic               started_q;

  // captured request
  logic signed [15:0] samp_q [NUM_AXES];
  logic               zero_q;
  logic               integ_q;
  logic               d_sign_q;
  logic [23:0]        d_mag_q;
  logic [15:0]        dt_q;

  // scalar chain
  logic [39:0] prod_q;
  logic [43:0] rate_p_q;
  logic [19:0] step_q;
  logic [7:0]  q_turn_q;
  logic [11:0] rem_q;

  // output register
  logic signed [11:0] yaw_out_q;
  logic signed [14:0] rate_out_q;
  logic signed [15:0] avg_out_q [NUM_AXES];

  // capture-side logic
  logic signed [24:0] d_full;
  logic [24:0]        d_neg;
  logic [31:0]        dt_raw;
  logic [15:0]        dt_clamp;
  logic               is_sample;

  assign is_sample = (req_type_i == REQ_SAMPLE);
  assign d_full    = {gyro_z_i[15], gyro_z_i, 8'd0} - {bias_q[23], bias_q};
  assign d_neg     = -d_full;
  assign dt_raw    = time_ms_i - last_time_q;
  assign dt_clamp  = (dt_raw > {16'd0, max_step_q}) ? max_step_q : dt_raw[15:0];

  // scalar chain logic
  logic [39:0] prod_d;
  logic [27:0] mag10;
  logic [43:0] rate_p_d;
  logic [14:0] rate_mag;
  logic [62:0] step_p;
  logic [40:0] turn_p;
  logic [19:0] turn_sub;
  logic [19:0] rem_full;

  assign prod_d   = 40'(d_mag_q) * 40'(dt_q);
  assign mag10    = {1'b0, d_mag_q, 3'd0} + {3'd0, d_mag_q, 1'b0};
  assign rate_p_d = 44'(mag10[27:7]) * 44'(RATE_RECIP);
  assign rate_mag = rate_p_q[43:RATE_SHIFT];
  assign step_p   = 63'(prod_q[39:9]) * 63'(STEP_RECIP);
  assign turn_p   = 41'(step_q) * 41'(WRAP_RECIP);
  assign turn_sub = 20'(q_turn_q) * 20'(YAW_FULL_U);
  assign rem_full = step_q - turn_sub;

  // heading wrap: rem_q is the step modulo one turn, direction from d
  logic signed [13:0] h_sum;
  logic signed [13:0] h_wrap;

  assign h_sum = d_sign_q ? ({{2{heading_q[11]}}, heading_q} - {2'b00, rem_q})
                          : ({{2{heading_q[11]}}, heading_q} + {2'b00, rem_q});

  always_comb begin
    h_wrap = h_sum;
    if (step_q == '0) begin
      h_wrap = {{2{heading_q[11]}}, heading_q};
    end else if (!d_sign_q) begin
      // forward step lands in (-1800, 1800]
      if (h_sum > YAW_HALF_S) begin
        h_wrap = h_sum - YAW_FULL_S;
      end else if (h_sum == -YAW_HALF_S) begin
        h_wrap = YAW_HALF_S;
      end
    end else begin
      // backward step lands in [-1800, 1800)
      if (h_sum < -YAW_HALF_S) begin
        h_wrap = h_sum + YAW_FULL_S;
      end else if (h_sum == YAW_HALF_S) begin
        h_wrap = -YAW_HALF_S;
      end
    end
  end

  // one axis average per step
  logic signed [15:0]   ax_x;
  logic signed [15:0]   ax_a;
  logic signed [16:0]   ax_diff;
  logic [16:0]          ax_diff_neg;
  logic [15:0]          ax_mag;
  logic [AX_PROD_W-1:0] ax_prod;
  logic [15:0]          ax_quo;
  logic [16:0]          ax_new;

  assign ax_x        = samp_q[cmd_i.step];
  assign ax_a        = avg_q[cmd_i.step];
  assign ax_diff     = {ax_x[15], ax_x} - {ax_a[15], ax_a};
  assign ax_diff_neg = -ax_diff;
  assign ax_mag      = ax_diff[16] ? ax_diff_neg[15:0] : ax_diff[15:0];
  assign ax_prod     = AX_PROD_W'(ax_mag) * AX_PROD_W'(SMOOTH_RECIP);
  assign ax_quo      = 16'(ax_prod >> SMOOTH_SHIFT);
  assign ax_new      = ax_diff[16] ? ({ax_a[15], ax_a} - {1'b0, ax_quo})
                                   : ({ax_a[15], ax_a} + {1'b0, ax_quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q      <= GYRO_BIAS_RST;
      max_step_q  <= MAX_STEP_RST;
      heading_q   <= '0;
      rate_q      <= '0;
      last_time_q <= '0;
      started_q   <= 1'b0;
      zero_q      <= 1'b0;
      integ_q     <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        avg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GYRO_BIAS: bias_q     <= cfg_data_i;
          CFG_MAX_STEP:  max_step_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        zero_q  <= ~is_sample;
        integ_q <= started_q & is_sample;
        if (is_sample) begin
          last_time_q <= time_ms_i;
          started_q   <= 1'b1;
        end else begin
          heading_q <= '0;
        end
      end
      if (cmd_i.run && !zero_q) begin
        avg_q[cmd_i.step] <= ax_new[15:0];
        if (cmd_i.step == STEP_RATE_WR) begin
          rate_q <= d_sign_q ? -rate_mag : rate_mag;
        end
        if (cmd_i.step == STEP_YAW_WR && integ_q) begin
          heading_q <= h_wrap[11:0];
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q[0] <= accel_x_i;
      samp_q[1] <= accel_y_i;
      samp_q[2] <= accel_z_i;
      samp_q[3] <= gyro_x_i;
      samp_q[4] <= gyro_y_i;
      samp_q[5] <= gyro_z_i;
      d_sign_q  <= d_full[24];
      d_mag_q   <= d_full[24] ? d_neg[23:0] : d_full[23:0];
      dt_q      <= dt_clamp;
    end
    if (cmd_i.run) begin
      prod_q   <= prod_d;
      rate_p_q <= rate_p_d;
      step_q   <= step_p[62:STEP_SHIFT];
      q_turn_q <= turn_p[39:WRAP_SHIFT];
      rem_q    <= rem_full[11:0];
    end
    if (cmd_i.load_out) begin
      yaw_out_q  <= heading_q;
      rate_out_q <= rate_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        avg_out_q[i] <= avg_q[i];
      end
    end
  end

  assign yaw_tenths_o     = yaw_out_q;
  assign rate_tenths_o    = rate_out_q;
  assign smooth_accel_x_o = avg_out_q[0];
  assign smooth_accel_y_o = avg_out_q[1];
  assign smooth_accel_z_o = avg_out_q[2];
  assign smooth_gyro_x_o  = avg_out_q[3];
  assign smooth_gyro_y_o  = avg_out_q[4];
  assign smooth_gyro_z_o  = avg_out_q[5];

endmodule

>>> src/imu_yaw_rate_integrator.sv
// Top level of the yaw-rate integrator: sequencer plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per beat:
//   a six-axis sample with a millisecond timestamp, or a heading-zero
//   request (req_type_i = 1). Every request yields exactly one result beat
//   on the output channel (out_valid_o / out_stall_i): heading, turn rate
//   and the six smoothed axes.
//   Sequence: the beat is taken, then six compute steps follow (one axis
//   average per step through a shared reciprocal multiplier, the rate and
//   heading chain running alongside), and then the result register is
//   loaded, waiting first while a stalled result is still held. No new beat
//   is taken until the result register is loaded and the block is idle
//   again; the six-step axis sequence sets the pace.
//   A held result does not block the next request: the block computes it
//   and waits only before loading the result register while out_stall_i is
//   high. Configuration writes (cfg_we_i) take effect at once; the user is to
//   make them while no request is in flight; the block does not enforce it.
//   Reset clears the averages, heading, rate and the timestamp-started flag;
//   bias resets to 0 and the step clamp to 100 ms.
module imu_yaw_rate_integrator
  import iyr_pkg::*;
#(
  parameter int SMOOTH_DIVISOR = SMOOTH_DIVISOR_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic signed [15:0]    accel_x_i,
  input  logic signed [15:0]    accel_y_i,
  input  logic signed [15:0]    accel_z_i,
  input  logic signed [15:0]    gyro_x_i,
  input  logic signed [15:0]    gyro_y_i,
  input  logic signed [15:0]    gyro_z_i,
  input  logic [31:0]           time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [11:0]    yaw_tenths_o,
  output logic signed [14:0]    rate_tenths_o,
  output logic signed [15:0]    smooth_accel_x_o,
  output logic signed [15:0]    smooth_accel_y_o,
  output logic signed [15:0]    smooth_accel_z_o,
  output logic signed [15:0]    smooth_gyro_x_o,
  output logic signed [15:0]    smooth_gyro_y_o,
  output logic signed [15:0]    smooth_gyro_z_o
);

  iyr_cmd_t cmd;

  iyr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  iyr_datapath #(
    .SMOOTH_DIVISOR (SMOOTH_DIVISOR)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .req_type_i       (req_type_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .gyro_x_i         (gyro_x_i),
    .gyro_y_i         (gyro_y_i),
    .gyro_z_i         (gyro_z_i),
    .time_ms_i        (time_ms_i),
    .yaw_tenths_o     (yaw_tenths_o),
    .rate_tenths_o    (rate_tenths_o),
    .smooth_accel_x_o (smooth_accel_x_o),
    .smooth_accel_y_o (smooth_accel_y_o),
    .smooth_accel_z_o (smooth_accel_z_o),
    .smooth_gyro_x_o  (smooth_gyro_x_o),
    .smooth_gyro_y_o  (smooth_gyro_y_o),
    .smooth_gyro_z_o  (smooth_gyro_z_o)
  );

`ifndef SYNTHESIS
  // an accepted beat always starts the compute sequence
  a_capture_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.run && (cmd.step == '0))
    else $error("accepted beat did not start compute");

  // the result register is never overwritten while a stalled result waits
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result register loaded over a stalled beat");

  // a new result only shows up after a load
  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("output valid without a load");

  // no new beat is taken while a request is in flight
  a_no_capture_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.run || cmd.load_out) |-> !cmd.capture)
    else $error("beat accepted while busy");
`endif

endmodule
